// ===== hdl/ssm_pkg.sv =====
// Package for the slot sound mixer: command, status and sequencer codes,
// sample limits and the memory request bundle.
// No dependencies; imported by ssm_sound_mem and slot_sound_mixer_top.
`timescale 1ns / 1ps

package ssm_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUEUE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Result codes of a queue request.
  typedef enum logic [1:0] {
    QS_OK      = 2'd0,
    QS_FULL    = 2'd1,
    QS_BAD_LEN = 2'd2
  } qstatus_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_WRITE_MEM,
    S_SEARCH,
    S_CLAIM,
    S_MIX_READ,
    S_MIX_ADD,
    S_DONE
  } state_t;

  // Strobes from the sequencer to the sound memory.
  typedef struct packed {
    logic we;
    logic re;
  } mem_req_t;

  // Longest clip that a slot accepts.
  localparam logic [16:0] MAX_CLIP_LEN = 17'h10000;

  // Limits of a 16-bit signed sample.
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;

endpackage

// ===== hdl/ssm_sound_mem.sv =====
// Sound memory of the slot sound mixer: one write port, one registered read port.
// Depends on ssm_pkg for the request bundle.
`timescale 1ns / 1ps

module ssm_sound_mem
  import ssm_pkg::*;
#(
  parameter int WORDS = 65536,
  parameter int AW    = 16
) (
  input  logic                clk,
  input  mem_req_t            req,
  input  logic [AW-1:0]       waddr,
  input  logic signed [15:0]  wdata,
  input  logic [AW-1:0]       raddr,
  output logic signed [15:0]  rdata
);

  logic [15:0] mem [WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/slot_sound_mixer_top.sv =====
// Top level of the slot sound mixer: sequencer, slot registers, shared adder.
// Depends on ssm_pkg and ssm_sound_mem.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   command, mem_address, mem_sample,
//                                              sound_start, sound_length
//   out_     output     out_valid / out_ready mixed_sample, queue_status,
//                                              slot_index, active_count
//
// One item is worked on at a time; in_ready is high only while the sequencer idles.
// A tick makes one memory read and one pass through the shared adder for every active
// slot and only steps past every free one. A load and a queue reduce their address by
// restoring steps that bring a 16-bit address below SOUND_WORDS; a queue first
// searches the slots for a free one.
// Reset (rst_n low, synchronous) frees every slot; the sound memory is not cleared.
// A result waits in the output register while out_ready is low; the next item is
// still taken, and only its own result stage waits for the register to empty.
`timescale 1ns / 1ps

module slot_sound_mixer_top
  import ssm_pkg::*;
#(
  parameter int NUM_SLOTS   = 16,
  parameter int SOUND_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_mem_address,
  input  logic signed [15:0] in_mem_sample,
  input  logic [15:0]        in_sound_start,
  input  logic [16:0]        in_sound_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mixed_sample,
  output logic [1:0]         out_queue_status,
  output logic [3:0]         out_slot_index,
  output logic [4:0]         out_active_count
);

  localparam int AW        = $clog2(SOUND_WORDS);
  localparam int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW        = $clog2(NUM_SLOTS + 1);
  localparam int RED_STEPS = $clog2((65536 + SOUND_WORDS - 1) / SOUND_WORDS);
  localparam int RED_KW    = 4;
  localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);
  localparam logic [AW-1:0] LAST_WORD = AW'(SOUND_WORDS - 1);

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [15:0]           val_r;
  logic signed [15:0]    sample_r;
  logic [16:0]           len_r;
  logic [IW-1:0]         idx_r;
  logic [RED_KW-1:0]     red_k_r;
  logic signed [15:0]    mix_r;
  qstatus_t              status_r;
  logic [IW-1:0]         slot_r;
  logic [CW-1:0]         cnt_r;
  logic [NUM_SLOTS-1:0]  slot_active_r;
  logic [AW-1:0]         slot_addr_r [NUM_SLOTS];
  logic [16:0]           slot_rem_r  [NUM_SLOTS];

  logic                  out_valid_r;
  logic signed [15:0]    out_mixed_r;
  logic [1:0]            out_status_r;
  logic [3:0]            out_slot_r;
  logic [4:0]            out_count_r;

  mem_req_t              mem_req;
  logic                  alu_mix;
  logic signed [15:0]    rd_data;

  logic                  cur_active;
  logic                  idx_last;
  logic                  red_last;
  logic                  len_bad;
  logic                  out_free;
  logic [15:0]           red_term;
  logic signed [16:0]    alu_a, alu_b, alu_sum;
  logic signed [15:0]    mix_sat;
  logic                  red_keep;

  // Conditions seen by the sequencer.
  assign cur_active = slot_active_r[idx_r];
  assign idx_last   = (idx_r == LAST_SLOT);
  assign red_last   = (RED_STEPS == 0) || (red_k_r == '0);
  assign len_bad    = (in_sound_length == '0) || (in_sound_length > MAX_CLIP_LEN);
  assign out_free   = !out_valid_r || out_ready;

  // Shared adder: saturating mix, or trial subtraction of SOUND_WORDS shifted left.
  assign red_term = 16'(32'(SOUND_WORDS) << red_k_r);

  always_comb begin
    if (alu_mix) begin
      alu_a = {mix_r[15], mix_r};
      alu_b = {rd_data[15], rd_data};
    end else begin
      alu_a = $signed({1'b0, val_r});
      alu_b = -$signed({1'b0, red_term});
    end
    alu_sum = alu_a + alu_b;
  end

  assign red_keep = !alu_sum[16];

  always_comb begin
    if (alu_sum[16] != alu_sum[15]) begin
      mix_sat = alu_sum[16] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      mix_sat = alu_sum[15:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_command))
            CMD_LOAD:  state_nxt = S_REDUCE;
            CMD_QUEUE: state_nxt = len_bad ? S_DONE : S_SEARCH;
            CMD_TICK:  state_nxt = S_MIX_READ;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_REDUCE: begin
        if (red_last) begin
          state_nxt = (cmd_r == CMD_LOAD) ? S_WRITE_MEM : S_CLAIM;
        end
      end
      S_WRITE_MEM: state_nxt = S_DONE;
      S_SEARCH: begin
        if (!cur_active) begin
          state_nxt = S_REDUCE;
        end else if (idx_last) begin
          state_nxt = S_DONE;
        end
      end
      S_CLAIM: state_nxt = S_DONE;
      S_MIX_READ: begin
        if (cur_active) begin
          state_nxt = S_MIX_ADD;
        end else if (idx_last) begin
          state_nxt = S_DONE;
        end
      end
      S_MIX_ADD: state_nxt = idx_last ? S_DONE : S_MIX_READ;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer strobes.
  always_comb begin
    in_ready   = 1'b0;
    mem_req.we = 1'b0;
    mem_req.re = 1'b0;
    alu_mix    = 1'b0;
    case (state_r)
      S_IDLE:      in_ready   = 1'b1;
      S_WRITE_MEM: mem_req.we = 1'b1;
      S_MIX_READ:  mem_req.re = cur_active;
      S_MIX_ADD:   alu_mix    = 1'b1;
      default: begin
      end
    endcase
  end

  // Registers of the sequencer, the slots and the output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_active_r <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The output register fills from the result stage and empties on a transfer.
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= cmd_t'(in_command);
            val_r    <= (cmd_t'(in_command) == CMD_LOAD) ? in_mem_address : in_sound_start;
            sample_r <= in_mem_sample;
            len_r    <= in_sound_length;
            idx_r    <= '0;
            red_k_r  <= RED_KW'(RED_STEPS - 1);
            mix_r    <= '0;
            slot_r   <= '0;
            status_r <= (cmd_t'(in_command) == CMD_QUEUE && len_bad) ? QS_BAD_LEN : QS_OK;
          end
        end
        S_REDUCE: begin
          if (RED_STEPS != 0) begin
            if (red_keep) begin
              val_r <= alu_sum[15:0];
            end
            red_k_r <= red_k_r - 1'b1;
          end
        end
        S_SEARCH: begin
          if (cur_active) begin
            if (idx_last) begin
              status_r <= QS_FULL;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_CLAIM: begin
          slot_active_r[idx_r] <= 1'b1;
          slot_addr_r[idx_r]   <= AW'(val_r);
          slot_rem_r[idx_r]    <= len_r;
          slot_r               <= idx_r;
          cnt_r                <= cnt_r + 1'b1;
        end
        S_MIX_READ: begin
          if (!cur_active && !idx_last) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_MIX_ADD: begin
          mix_r <= mix_sat;
          slot_addr_r[idx_r] <= (slot_addr_r[idx_r] == LAST_WORD) ? '0
                                : slot_addr_r[idx_r] + 1'b1;
          slot_rem_r[idx_r]  <= slot_rem_r[idx_r] - 1'b1;
          // The slot whose last sample was just mixed is freed.
          if (slot_rem_r[idx_r] == 17'd1) begin
            slot_active_r[idx_r] <= 1'b0;
            cnt_r                <= cnt_r - 1'b1;
          end
          if (!idx_last) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_mixed_r  <= mix_r;
            out_status_r <= status_r;
            out_slot_r   <= 4'(slot_r);
            out_count_r  <= 5'(cnt_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sound memory.
  ssm_sound_mem #(
    .WORDS (SOUND_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .waddr (AW'(val_r)),
    .wdata (sample_r),
    .raddr (slot_addr_r[idx_r]),
    .rdata (rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_mixed_r;
  assign out_queue_status = out_status_r;
  assign out_slot_index   = out_slot_r;
  assign out_active_count = out_count_r;

`ifndef NO_ASSERTIONS
  // The running count always matches the occupied slots.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CW'($countones(slot_active_r)))
    else $error("active count differs from occupied slots");

  // A result appears only out of the result stage.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the result stage");

  // The memory is written only for a load.
  a_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> cmd_r == CMD_LOAD)
    else $error("sound memory written by a non-load item");

  // A full report is given only when every slot is taken.
  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == QS_FULL) |-> (&slot_active_r))
    else $error("no-free-slot reported with a slot free");

  // An accepted transfer starts the sequencer.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != S_IDLE)
    else $error("accepted item left the sequencer idle");
`endif

endmodule
